FILE: rtl/bayer_black_level_bilinear_demosaic_defines.svh
// Assertion macros used by the checker file of the demosaic block.
`ifndef BAYER_BLACK_LEVEL_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_BLACK_LEVEL_BILINEAR_DEMOSAIC_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BBLD_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("bbld check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BBLD_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("bbld check failed");

`endif

FILE: rtl/bbld_pkg.sv
package bbld_pkg;

    // Register indexes, decoded from paddr[3:2].
    localparam logic [1:0] REG_BLACK_LEVEL  = 2'd0;
    localparam logic [1:0] REG_NORM_GAIN    = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic [15:0] BLACK_LEVEL_RST  = 16'd0;
    localparam logic [31:0] NORM_GAIN_RST    = 32'd65537;
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd4096;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1;

    localparam logic [15:0] PIX_MAX = 16'hFFFF;

    // Line store word: row above in the upper half, center row in the lower half.
    localparam int LINE_DW = 32;

    // Result queue.
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;

    // Per-transaction control produced by the position counters.
    typedef struct packed {
        logic c0;        // column zero of a row
        logic m0;        // row above lies inside the frame
        logic m1;        // center row lies inside the frame
        logic m2;        // new sample is real (inside the frame, not a flush)
        logic emit;      // this transaction releases a pixel
        logic last;      // released pixel is the last one of the frame
        logic even_row;  // parity of the released pixel
        logic even_col;
    } t_ctl;

    // 3x3 window, index [row][column]; row 0 is the oldest row.
    typedef logic [2:0][2:0][15:0] t_win;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        frame_end;
    } t_pix;

    function automatic logic [15:0] sat_inc16(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

endpackage

FILE: rtl/bbld_line_mem.sv
module bbld_line_mem
    import bbld_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [LINE_DW-1:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [LINE_DW-1:0] i_wr_data
);

    logic [LINE_DW-1:0] r_mem [DEPTH];
    logic [LINE_DW-1:0] r_rd_data;

    // A read and a write to the same entry in one cycle return the old word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/bbld_ctrl.sv
module bbld_ctrl
    import bbld_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_flush,
    input  logic [12:0]                  i_frame_width,
    input  logic [15:0]                  i_frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0] o_addr,
    output t_ctl                         o_ctl
);

    localparam int IW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > 13) ? WW : 13;

    logic [IW-1:0] r_in_col,  n_in_col;
    logic [15:0]   r_in_row,  n_in_row;
    logic [IW-1:0] r_out_col, n_out_col;
    logic [15:0]   r_out_row, n_out_row;

    logic [CW-1:0] fw_ext;
    logic [WW-1:0] w;
    logic [15:0]   h;
    logic          wrap0;
    logic [IW-1:0] c;
    logic [15:0]   r;
    logic [WW-1:0] oc1;
    logic [16:0]   or1;
    logic [WW-1:0] cn1;
    t_ctl          ctl;

    always_comb begin
        fw_ext = CW'(i_frame_width);
        if (i_frame_width == 13'd0) begin
            w = WW'(1);
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(fw_ext);
        end
        h = (i_frame_height == 16'd0) ? 16'd1 : i_frame_height;

        // A column left beyond a narrowed width wraps to the next row first.
        wrap0 = (WW'(r_in_col) >= w);
        c     = wrap0 ? '0 : r_in_col;
        r     = wrap0 ? sat_inc16(r_in_row) : r_in_row;

        oc1 = WW'(r_out_col) + WW'(1);
        or1 = {1'b0, r_out_row} + 17'd1;
        cn1 = WW'(c) + WW'(1);

        ctl.c0       = (c == '0);
        ctl.m0       = (r >= 16'd2) && ((r - 16'd2) < h);
        ctl.m1       = (r != 16'd0) && ((r - 16'd1) < h);
        ctl.m2       = !i_flush && (r < h);
        ctl.emit     = (r >= 16'd2) || ((r == 16'd1) && (c != '0));
        ctl.last     = ctl.emit && (oc1 >= w) && (or1 >= {1'b0, h});
        ctl.even_row = !r_out_row[0];
        ctl.even_col = !r_out_col[0];

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_accept) begin
            if (ctl.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (ctl.emit) begin
                    if (oc1 >= w) begin
                        n_out_col = '0;
                        n_out_row = sat_inc16(r_out_row);
                    end else begin
                        n_out_col = IW'(oc1);
                    end
                end
                if (cn1 >= w) begin
                    n_in_col = '0;
                    n_in_row = sat_inc16(r);
                end else begin
                    n_in_col = IW'(cn1);
                    n_in_row = r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_addr = c;
    assign o_ctl  = ctl;

endmodule

FILE: rtl/bbld_demosaic.sv
module bbld_demosaic
    import bbld_pkg::*;
(
    input  t_win i_win,
    input  logic i_even_row,
    input  logic i_even_col,
    input  logic i_last,
    output t_pix o_pix
);

    logic [17:0] cross_sum;
    logic [17:0] corner_sum;
    logic [16:0] horiz_sum;
    logic [16:0] vert_sum;

    always_comb begin
        horiz_sum  = {1'b0, i_win[1][0]} + {1'b0, i_win[1][2]};
        vert_sum   = {1'b0, i_win[0][1]} + {1'b0, i_win[2][1]};
        cross_sum  = {1'b0, horiz_sum} + {1'b0, vert_sum};
        corner_sum = 18'(i_win[0][0]) + 18'(i_win[0][2])
                   + 18'(i_win[2][0]) + 18'(i_win[2][2]);

        o_pix.frame_end = i_last;
        if (i_even_row && i_even_col) begin
            o_pix.red   = i_win[1][1];
            o_pix.green = cross_sum[17:2];
            o_pix.blue  = corner_sum[17:2];
        end else if (i_even_row) begin
            o_pix.red   = horiz_sum[16:1];
            o_pix.green = i_win[1][1];
            o_pix.blue  = vert_sum[16:1];
        end else if (i_even_col) begin
            o_pix.red   = vert_sum[16:1];
            o_pix.green = i_win[1][1];
            o_pix.blue  = horiz_sum[16:1];
        end else begin
            o_pix.red   = corner_sum[17:2];
            o_pix.green = cross_sum[17:2];
            o_pix.blue  = i_win[1][1];
        end
    end

endmodule

FILE: rtl/bbld_out_fifo.sv
module bbld_out_fifo
    import bbld_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_pix             i_pix,
    output logic             o_valid,
    input  logic             i_ready,
    output t_pix             o_pix,
    output logic [OQ_AW:0]   o_count
);

    t_pix             r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wptr, n_wptr;
    logic [OQ_AW-1:0] r_rptr, n_rptr;
    logic [OQ_AW:0]   r_count, n_count;
    logic             pop;

    always_comb begin
        pop     = (r_count != '0) && i_ready;
        n_wptr  = i_push ? r_wptr + OQ_AW'(1) : r_wptr;
        n_rptr  = pop ? r_rptr + OQ_AW'(1) : r_rptr;
        n_count = r_count + (OQ_AW+1)'(i_push) - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_pix;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_pix   = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

FILE: rtl/bayer_black_level_bilinear_demosaic.sv
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ---------------------------------
// in        input      i_in_valid / o_in_ready    i_raw_sample, i_flush
// out       output     o_out_valid / i_out_ready  o_red, o_green, o_blue, o_frame_end
// config    input      psel / penable / pready    pwrite, paddr, pwdata, prdata
//
// One transaction per clock is taken while o_in_ready is high; the line store has
// one read and one write port, and each transaction uses each once. A result
// passes the stage 1, 2 and 3 registers and the result queue to reach o_out_valid.
// Reset is synchronous and active low; the line store needs no clearing pass.
// The pipeline never stalls. o_in_ready drops only when the eight-entry result
// queue plus the transactions still in the pipeline would overflow it.
module bayer_black_level_bilinear_demosaic
    import bbld_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_raw_sample,
    input  logic        i_flush,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue,
    output logic        o_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_WIDTH);

    // Configuration registers.
    logic [15:0] r_black_level;
    logic [31:0] r_norm_gain;
    logic [12:0] r_frame_width;
    logic [15:0] r_frame_height;
    logic        cfg_wr;

    // Stage 0: accept, position counters and line store read.
    logic          accept;
    logic [IW-1:0] s0_addr;
    t_ctl          s0_ctl;
    logic [15:0]   s0_sub;

    // Stage 1: gain multiply and read forwarding.
    logic               r1_v;
    t_ctl               r1_ctl;
    logic [IW-1:0]      r1_addr;
    logic [15:0]        r1_sub;
    logic [47:0]        s1_prod;
    logic [LINE_DW-1:0] mem_rd;
    logic [LINE_DW-1:0] s1_rd;

    // Stage 2: saturation, line store write and window shift.
    logic               r2_v;
    t_ctl               r2_ctl;
    logic [IW-1:0]      r2_addr;
    logic [47:0]        r2_prod;
    logic [LINE_DW-1:0] r2_rd;
    logic [15:0]        s2_norm;
    logic [2:0][15:0]   s2_col;
    logic [LINE_DW-1:0] s2_wd;
    t_win               n_e;

    // Stage 3: demosaic into the result queue.
    logic               r3_v;
    t_ctl               r3_ctl;
    logic [IW-1:0]      r3_addr;
    logic [LINE_DW-1:0] r3_wd;
    t_win               r_e;
    logic [2:0][15:0]   r_raw;
    logic               r_c0p;
    logic               r_wz;
    t_pix               s3_pix;

    logic [OQ_AW:0]     oq_count;
    logic [OQ_AW+1:0]   pending;
    t_pix               oq_pix;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // decoded straight from the address.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_level  <= BLACK_LEVEL_RST;
            r_norm_gain    <= NORM_GAIN_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BLACK_LEVEL:  r_black_level  <= pwdata[15:0];
                REG_NORM_GAIN:    r_norm_gain    <= pwdata;
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[12:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[15:0];
                default:          r_black_level  <= r_black_level;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLACK_LEVEL:  prdata = {16'd0, r_black_level};
            REG_NORM_GAIN:    prdata = r_norm_gain;
            REG_FRAME_WIDTH:  prdata = {19'd0, r_frame_width};
            REG_FRAME_HEIGHT: prdata = {16'd0, r_frame_height};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. Every transaction in flight may still need a queue slot,
    // so the input is held off once those slots are spoken for.
    // ------------------------------------------------------------------
    assign pending    = (OQ_AW+2)'(oq_count) + (OQ_AW+2)'(r1_v)
                      + (OQ_AW+2)'(r2_v) + (OQ_AW+2)'(r3_v);
    assign o_in_ready = (pending < (OQ_AW+2)'(OQ_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Stage 0
    // ------------------------------------------------------------------
    bbld_ctrl #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_flush        (i_flush),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_addr         (s0_addr),
        .o_ctl          (s0_ctl)
    );

    // Black level subtraction, floored at zero.
    assign s0_sub = (i_raw_sample > r_black_level) ? i_raw_sample - r_black_level : 16'd0;

    // The line store holds the row above and the center row side by side, so
    // one read gives both vertical neighbors and one write shifts the rows.
    bbld_line_mem #(
        .DEPTH(MAX_WIDTH),
        .AW   (IW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (s0_addr),
        .o_rd_data (mem_rd),
        .i_wr_en   (r2_v),
        .i_wr_addr (r2_addr),
        .i_wr_data (s2_wd)
    );

    // ------------------------------------------------------------------
    // Stage 1. Narrow frames revisit a column before its earlier update has
    // landed: the transaction in stage 2 writes only at the coming edge, and
    // the one in stage 3 wrote at the edge on which this read was taken.
    // Both are forwarded, the younger one first.
    // ------------------------------------------------------------------
    assign s1_prod = r1_sub * r_norm_gain;

    always_comb begin
        if (r2_v && (r2_addr == r1_addr)) begin
            s1_rd = s2_wd;
        end else if (r3_v && (r3_addr == r1_addr)) begin
            s1_rd = r3_wd;
        end else begin
            s1_rd = mem_rd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2. The Q16.16 product is truncated and saturated to 16 bits;
    // rows outside the frame read as zero.
    // ------------------------------------------------------------------
    always_comb begin
        s2_norm   = (r2_prod[47:32] != 16'd0) ? PIX_MAX : r2_prod[31:16];
        s2_col[0] = r2_ctl.m0 ? r2_rd[31:16] : 16'd0;
        s2_col[1] = r2_ctl.m1 ? r2_rd[15:0]  : 16'd0;
        s2_col[2] = r2_ctl.m2 ? s2_norm      : 16'd0;
        s2_wd     = {r2_rd[15:0], s2_col[2]};
    end

    // The window register holds the view used for the pixel just released.
    // The running window behind it is that view, except that it is all zero
    // after a frame end, and that after a row start it holds only the first
    // column of the new row. The next view shifts that running window left
    // and brings in the new column, zero at a row start (the right-hand
    // neighbor of the previous row's last pixel lies outside the image).
    always_comb begin
        n_e = r_e;
        for (int i = 0; i < 3; i++) begin
            n_e[i][0] = (r_wz || r_c0p) ? 16'd0 : r_e[i][1];
            n_e[i][1] = r_wz ? 16'd0 : (r_c0p ? r_raw[i] : r_e[i][2]);
            n_e[i][2] = r2_ctl.c0 ? 16'd0 : s2_col[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3
    // ------------------------------------------------------------------
    bbld_demosaic u_demosaic (
        .i_win      (r_e),
        .i_even_row (r3_ctl.even_row),
        .i_even_col (r3_ctl.even_col),
        .i_last     (r3_ctl.last),
        .o_pix      (s3_pix)
    );

    bbld_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r3_v && r3_ctl.emit),
        .i_pix   (s3_pix),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pix   (oq_pix),
        .o_count (oq_count)
    );

    assign o_red       = oq_pix.red;
    assign o_green     = oq_pix.green;
    assign o_blue      = oq_pix.blue;
    assign o_frame_end = oq_pix.frame_end;

    // ------------------------------------------------------------------
    // Pipeline control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_wz  <= 1'b1;
            r_c0p <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            if (r2_v) begin
                r_wz  <= r2_ctl.last;
                r_c0p <= r2_ctl.c0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_ctl  <= s0_ctl;
            r1_addr <= s0_addr;
            r1_sub  <= s0_sub;
        end
        if (r1_v) begin
            r2_ctl  <= r1_ctl;
            r2_addr <= r1_addr;
            r2_prod <= s1_prod;
            r2_rd   <= s1_rd;
        end
        if (r2_v) begin
            r3_ctl  <= r2_ctl;
            r3_addr <= r2_addr;
            r3_wd   <= s2_wd;
            r_e     <= n_e;
            r_raw   <= s2_col;
        end
    end

endmodule

FILE: rtl/bbld_checker.sv
`include "bayer_black_level_bilinear_demosaic_defines.svh"

module bbld_checker
    import bbld_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [15:0] i_raw_sample,
    input logic        i_flush,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_red,
    input logic [15:0] o_green,
    input logic [15:0] o_blue,
    input logic        o_frame_end,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result holds its value.
    `BBLD_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_frame_end))

    // Reset empties the result queue.
    `BBLD_ASSERT_NXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // A result can only appear after an accepted input transaction.
    `BBLD_ASSERT_IMP(a_out_after_in, i_clk, !i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 4))

    // A gain write reads back on the following cycle.
    `BBLD_ASSERT_NXT(a_gain_readback, i_clk, !i_rst_n, psel && penable && pwrite && pready && (paddr[3:2] == REG_NORM_GAIN), (paddr[3:2] != REG_NORM_GAIN) || (prdata == $past(pwdata)))

endmodule

bind bayer_black_level_bilinear_demosaic bbld_checker u_bbld_checker (.*);
